/* sv/isp_pkg.sv */
// Shared widths, register indexes and sizes for the image slice profile block.
package isp_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int VALUE_W      = 34;
  localparam int INDEX_W      = 10;
  localparam int MAX_TIME     = 1024;
  localparam int MAX_CHANNELS = 256;
  localparam int TADDR_W      = $clog2(MAX_TIME);
  localparam int CHAN_W       = $clog2(MAX_CHANNELS);
  localparam int NCH_W        = 9;
  localparam int NT_W         = 11;
  localparam int WIN_W        = 16;
  localparam int LEN_W        = 11;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // The divider retires one quotient bit per cycle.
  localparam int DIV_STEPS    = VALUE_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_TEMPORAL_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAKE_WHOLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES       = 3'd6;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

/* sv/isp_div.sv */
// Sequential signed divider: a 34-bit sum by an unsigned window length, truncating toward zero.
module isp_div
  import isp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  value_t              dividend,
  input  logic [LEN_W-1:0]    divisor,
  output logic                done,
  output value_t              quotient
);

  logic [VALUE_W-1:0]   quot;
  logic [LEN_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy;
  logic                 neg;
  logic [LEN_W:0]       trial;
  logic                 take;

  // One restoring step: bring down the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem, quot[VALUE_W-1]};
    take  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[VALUE_W-1];
      quot <= dividend[VALUE_W-1] ? (~dividend + 1'b1) : dividend;
      rem  <= '0;
    end else if (busy) begin
      rem  <= take ? LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
      quot <= {quot[VALUE_W-2:0], take};
    end
  end

  assign quotient = neg ? -signed'(quot) : signed'(quot);

endmodule

/* sv/image_slice_profile.sv */
// Top level of the image slice profile block: frame counters, accumulator memory and control.
//
// The block takes the samples of a channels-by-time frame in channel-major order (all time
// samples of channel 0, then channel 1, and so on) and produces a windowed projection profile.
// With temporal_mode clear it sums each channel over the time window and emits one beat on the
// channel's last sample, indexed by channel. With temporal_mode set it keeps one accumulator per
// time index in a 1024-entry memory, sums over the channel window, and emits one beat per time
// index during the frame's last channel, indexed by time. Window limits are clamped to the
// active axis; take_whole uses the whole axis. With normalize set each sum is divided by the
// window length (at least one), truncating toward zero. Every addition saturates to 34 bits.
// frame_last marks the final beat of a frame. Items are handled one at a time: a sample that
// produces no beat passes through accept and then the accumulator read-modify-write against
// the memory's registered read; a sample that produces a beat also waits for the output
// register, after the bit-serial divider when normalize is set and the window is longer than
// one. A finished beat sits in the output register, so the next sample can be taken while it
// waits; a later beat waits for that register to drain. The user must write configuration
// only while the block is idle; the block does not enforce it. The accumulator memory is not
// cleared after reset: the first channel of each frame in temporal mode overwrites its entry.
module image_slice_profile
  import isp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VALUE_W-1:0]   profile_value,
  output logic [INDEX_W-1:0]          profile_index,
  output logic                        frame_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PEND = 2'd3;

  localparam logic signed [VALUE_W:0] SUM_MAX = {2'b00, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W:0] SUM_MIN = {2'b11, {(VALUE_W-1){1'b0}}};

  // Configuration registers.
  logic                    temporal_mode;
  logic                    take_whole;
  logic signed [WIN_W-1:0] window_low;
  logic signed [WIN_W-1:0] window_high;
  logic                    normalize;
  logic [NCH_W-1:0]        channels_in_frame;
  logic [NT_W-1:0]         samples_per_channel;

  // Frame position and the running channel sum.
  logic [TADDR_W-1:0]      time_counter;
  logic [CHAN_W-1:0]       channel_counter;
  value_t                  channel_sum;

  logic [1:0]              state;
  logic [1:0]              state_next;

  // Accumulator memory, one entry per time index.
  value_t                  time_sums [MAX_TIME];
  value_t                  mem_rdata;
  logic                    mem_we;

  // Item captured at accept.
  logic signed [SAMPLE_W-1:0] it_sample;
  logic                    it_in_win;
  logic                    it_first;
  logic                    it_temporal;
  logic                    it_last_t;
  logic                    it_emit;
  logic                    it_div;
  logic [LEN_W-1:0]        it_len;
  logic [TADDR_W-1:0]      it_tidx;
  logic [INDEX_W-1:0]      it_index;
  logic                    it_frame_last;

  value_t                  res_value;
  logic [INDEX_W-1:0]      res_index;
  logic                    res_last;

  // Decode of the current sample's position against the registers.
  logic                    in_accept;
  logic                    out_accept;
  logic                    out_free;
  logic [NCH_W-1:0]        nch;
  logic [NT_W-1:0]         nt;
  logic [LEN_W-1:0]        axis;
  logic signed [WIN_W:0]   axis_s;
  logic signed [WIN_W:0]   wl_s;
  logic signed [WIN_W:0]   wh_s;
  logic [LEN_W-1:0]        lo;
  logic [LEN_W-1:0]        hi;
  logic [LEN_W-1:0]        pos;
  logic                    last_t;
  logic                    last_ch;

  // Accumulate stage.
  value_t                  contrib;
  value_t                  base;
  logic signed [VALUE_W:0] sum_wide;
  value_t                  sum_sat;

  div_ctl_t                div_ctl;
  value_t                  div_q;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = rst || (state != S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      temporal_mode       <= 1'b0;
      take_whole          <= 1'b1;
      window_low          <= '0;
      window_high         <= WIN_W'(1000);
      normalize           <= 1'b0;
      channels_in_frame   <= NCH_W'(MAX_CHANNELS);
      samples_per_channel <= NT_W'(MAX_TIME);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMPORAL_MODE: temporal_mode       <= cfg_data[0];
        REG_TAKE_WHOLE:    take_whole          <= cfg_data[0];
        REG_WINDOW_LOW:    window_low          <= signed'(cfg_data);
        REG_WINDOW_HIGH:   window_high         <= signed'(cfg_data);
        REG_NORMALIZE:     normalize           <= cfg_data[0];
        REG_CHANNELS:      channels_in_frame   <= cfg_data[NCH_W-1:0];
        REG_SAMPLES:       samples_per_channel <= cfg_data[NT_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame sizes: zero acts as one, anything beyond the maximum acts as the maximum.
  // The window is then clamped to the axis that the mode sums over.
  always_comb begin
    if (channels_in_frame == '0) begin
      nch = NCH_W'(1);
    end else if (channels_in_frame > NCH_W'(MAX_CHANNELS)) begin
      nch = NCH_W'(MAX_CHANNELS);
    end else begin
      nch = channels_in_frame;
    end
    if (samples_per_channel == '0) begin
      nt = NT_W'(1);
    end else if (samples_per_channel > NT_W'(MAX_TIME)) begin
      nt = NT_W'(MAX_TIME);
    end else begin
      nt = samples_per_channel;
    end

    axis   = temporal_mode ? LEN_W'(nch) : LEN_W'(nt);
    axis_s = signed'({(WIN_W+1-LEN_W)'(0), axis});
    wl_s   = (WIN_W+1)'(window_low);
    wh_s   = (WIN_W+1)'(window_high);

    if (take_whole || wl_s < 0) begin
      lo = '0;
    end else if (wl_s > axis_s) begin
      lo = axis;
    end else begin
      lo = wl_s[LEN_W-1:0];
    end
    if (take_whole || wh_s > axis_s) begin
      hi = axis;
    end else if (wh_s < 0) begin
      hi = '0;
    end else begin
      hi = wh_s[LEN_W-1:0];
    end

    pos     = temporal_mode ? LEN_W'(channel_counter) : LEN_W'(time_counter);
    last_t  = ({1'b0, time_counter} + 1'b1) >= NT_W'(nt);
    last_ch = ({1'b0, channel_counter} + 1'b1) >= nch;
  end

  // Capture the item and advance the frame position at accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_counter    <= '0;
      channel_counter <= '0;
    end else if (in_accept) begin
      if (last_t) begin
        time_counter    <= '0;
        channel_counter <= last_ch ? '0 : channel_counter + 1'b1;
      end else begin
        time_counter    <= time_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      it_sample     <= sample;
      it_in_win     <= (pos >= lo) && (pos < hi);
      it_first      <= (channel_counter == '0);
      it_temporal   <= temporal_mode;
      it_last_t     <= last_t;
      it_emit       <= temporal_mode ? last_ch : last_t;
      it_len        <= (hi > lo) ? LEN_W'(hi - lo) : LEN_W'(1);
      it_div        <= normalize && (hi > lo) && (LEN_W'(hi - lo) != LEN_W'(1));
      it_tidx       <= time_counter;
      it_index      <= temporal_mode ? INDEX_W'(time_counter) : INDEX_W'(channel_counter);
      it_frame_last <= temporal_mode ? last_t : last_ch;
    end
  end

  // The read is issued at accept; the entry is written back in the next cycle, before the
  // next item can be accepted, so a read never races a pending write to the same entry.
  assign mem_we = (state == S_ACC) && it_temporal;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem_rdata <= time_sums[time_counter];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_sums[it_tidx] <= sum_sat;
    end
  end

  // Saturating accumulate. The first channel of a frame starts its time entry from zero.
  always_comb begin
    contrib = it_in_win ? VALUE_W'(it_sample) : '0;
    if (it_temporal) begin
      base = it_first ? '0 : mem_rdata;
    end else begin
      base = channel_sum;
    end
    sum_wide = (VALUE_W+1)'(base) + (VALUE_W+1)'(contrib);
    if (sum_wide > SUM_MAX) begin
      sum_sat = VALUE_W'(SUM_MAX);
    end else if (sum_wide < SUM_MIN) begin
      sum_sat = VALUE_W'(SUM_MIN);
    end else begin
      sum_sat = sum_wide[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_sum <= '0;
    end else if (state == S_ACC && !it_temporal) begin
      channel_sum <= it_last_t ? '0 : sum_sat;
    end
  end

  assign div_ctl.start = (state == S_ACC) && it_emit && it_div;

  isp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_ctl.start),
    .dividend (sum_sat),
    .divisor  (it_len),
    .done     (div_ctl.done),
    .quotient (div_q)
  );

  // Item sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_accept) state_next = S_ACC;
      S_ACC: begin
        if (!it_emit) begin
          state_next = S_IDLE;
        end else if (it_div) begin
          state_next = S_DIV;
        end else begin
          state_next = S_PEND;
        end
      end
      S_DIV:  if (div_ctl.done) state_next = S_PEND;
      S_PEND: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result waiting for the output register.
  always_ff @(posedge clk) begin
    if (state == S_ACC) begin
      res_value <= sum_sat;
      res_index <= it_index;
      res_last  <= it_frame_last;
    end else if (state == S_DIV && div_ctl.done) begin
      res_value <= div_q;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PEND && out_free) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PEND && out_free) begin
      profile_value <= res_value;
      profile_index <= res_index;
      frame_last    <= res_last;
    end
  end

endmodule

/* sv/isp_check.sv */
// Port-level checks for the image slice profile block, bound to the top level.
module isp_check
  import isp_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [VALUE_W-1:0]  profile_value,
  input logic [INDEX_W-1:0]         profile_index,
  input logic                       frame_last
);

  // One item is in work at a time, so an accepted beat closes the input for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item was in work");

  // A new result is loaded only while the input side is closed by work in progress.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(profile_value) && $stable(profile_index) && $stable(frame_last)))
    else $error("stalled result beat changed");

endmodule

bind image_slice_profile isp_check u_isp_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .profile_value (profile_value),
  .profile_index (profile_index),
  .frame_last    (frame_last)
);

/* tb/sv/tb_image_slice_profile.sv */
// Self-checking testbench for the image slice profile block with a scoreboard class.
module tb_image_slice_profile;
  import isp_pkg::*;

  // The run is cut off here; a correct run needs a small fraction of it.
  localparam int LIMIT_CYCLES  = 1000000;
  // Cycles to let pass after the last expected beat before the block counts as idle.
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_ITEMS  = 1000;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum int {STYLE_FULL, STYLE_SMALL, STYLE_EXTREME, STYLE_MIN} sample_style_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pattern_t;

  typedef struct packed {
    value_t             value;
    logic [INDEX_W-1:0] index;
    logic               last;
  } profile_beat_t;

  // The scoreboard keeps its own copy of the registers, the frame counters and the
  // accumulators, predicts the beat that each accepted sample causes and checks the
  // beats leaving the block against those predictions in order.
  class profile_scoreboard;
    bit          temporal;
    bit          whole;
    int          win_lo;
    int          win_hi;
    bit          norm;
    int unsigned nch_reg;
    int unsigned nt_reg;

    longint      time_acc [MAX_TIME];
    longint      chan_acc;
    int unsigned ch_cnt;
    int unsigned t_cnt;

    profile_beat_t profile_due [$];
    int          noted;
    int          checked;
    int          errors;

    function new();
      temporal = 1'b0;
      whole    = 1'b1;
      win_lo   = 0;
      win_hi   = 1000;
      norm     = 1'b0;
      nch_reg  = 256;
      nt_reg   = 1024;
      foreach (time_acc[i]) time_acc[i] = 0;
      chan_acc = 0;
      ch_cnt   = 0;
      t_cnt    = 0;
      noted    = 0;
      checked  = 0;
      errors   = 0;
    endfunction

    function int unsigned fit_size(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function longint sat34(longint s);
      longint top;
      top = (longint'(1) <<< (VALUE_W - 1)) - 1;
      if (s > top) return top;
      if (s < -top - 1) return -top - 1;
      return s;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_TEMPORAL_MODE: temporal = d[0];
        REG_TAKE_WHOLE:    whole = d[0];
        REG_WINDOW_LOW:    win_lo = int'($signed(d));
        REG_WINDOW_HIGH:   win_hi = int'($signed(d));
        REG_NORMALIZE:     norm = d[0];
        REG_CHANNELS:      nch_reg = 32'(d[NCH_W-1:0]);
        REG_SAMPLES:       nt_reg = 32'(d[NT_W-1:0]);
        default: ;
      endcase
    endfunction

    function bit at_frame_start();
      return ch_cnt == 0 && t_cnt == 0;
    endfunction

    function int frame_size();
      return fit_size(nch_reg, MAX_CHANNELS) * fit_size(nt_reg, MAX_TIME);
    endfunction

    // Samples still needed to close the current frame under the present sizes. A counter
    // left past a shrunk size counts as sitting on the last index.
    function int samples_to_frame_end();
      int unsigned nch;
      int unsigned nt;
      if (at_frame_start()) return 0;
      nch = fit_size(nch_reg, MAX_CHANNELS);
      nt  = fit_size(nt_reg, MAX_TIME);
      return ((t_cnt + 1 >= nt) ? 1 : nt - t_cnt) +
             ((ch_cnt + 1 >= nch) ? 0 : (nch - ch_cnt - 1) * nt);
    endfunction

    function int pending();
      return profile_due.size();
    endfunction

    function void push_beat(longint sum, longint len, int unsigned idx, bit last);
      profile_beat_t b;
      longint val;
      val = norm ? sum / len : sum;
      b.value = val[VALUE_W-1:0];
      b.index = idx[INDEX_W-1:0];
      b.last  = last;
      profile_due.push_back(b);
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      int unsigned nch;
      int unsigned nt;
      int unsigned tidx;
      int          axis;
      int          lo;
      int          hi;
      longint      x;
      longint      len;
      bit          last_t;
      bit          last_ch;
      bit          hit;
      nch  = fit_size(nch_reg, MAX_CHANNELS);
      nt   = fit_size(nt_reg, MAX_TIME);
      axis = temporal ? int'(nch) : int'(nt);
      lo   = win_lo;
      hi   = win_hi;
      if (lo < 0 || whole) lo = 0;
      if (hi < 0) hi = 0;
      if (hi > axis || whole) hi = axis;
      if (lo > axis) lo = axis;
      len = hi - lo;
      if (len < 1) len = 1;
      x       = s;
      last_t  = (t_cnt + 1 >= nt);
      last_ch = (ch_cnt + 1 >= nch);
      tidx    = t_cnt % MAX_TIME;
      noted++;

      if (temporal) begin
        hit = int'(ch_cnt) >= lo && int'(ch_cnt) < hi;
        // The first channel starts the per-time sum afresh.
        time_acc[tidx] = sat34(((ch_cnt == 0) ? longint'(0) : time_acc[tidx]) +
                               (hit ? x : longint'(0)));
        if (last_ch) push_beat(time_acc[tidx], len, t_cnt, last_t);
      end else begin
        if (int'(t_cnt) >= lo && int'(t_cnt) < hi) chan_acc = sat34(chan_acc + x);
        if (last_t) begin
          push_beat(chan_acc, len, ch_cnt, last_ch);
          chan_acc = 0;
        end
      end

      if (last_t) begin
        t_cnt  = 0;
        ch_cnt = last_ch ? 0 : ch_cnt + 1;
      end else begin
        t_cnt++;
      end
    endfunction

    function void check_beat(value_t v, logic [INDEX_W-1:0] idx, logic last);
      profile_beat_t e;
      if (profile_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected beat: value %0d index %0d last %0b", v, idx, last);
        return;
      end
      e = profile_due.pop_front();
      checked++;
      if (v !== e.value || idx !== e.index || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("Beat %0d: value exp %0d got %0d, index exp %0d got %0d, last exp %0b got %0b",
                   checked, e.value, v, e.index, idx, e.last, last);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [VALUE_W-1:0]  profile_value;
  logic [INDEX_W-1:0]         profile_index;
  logic                       frame_last;

  profile_scoreboard sb;
  int                cycles = 0;
  int                burst_left = 0;
  int                settings_used = 0;
  stall_pattern_t    stall_mode = STALL_NONE;
  int                stall_span = 0;

  image_slice_profile uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .profile_value (profile_value),
    .profile_index (profile_index),
    .frame_last    (frame_last)
  );

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    sample    = '0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  // The receiver switches between stall patterns at random intervals: no stall at all,
  // light and heavy random stalls, and a fixed periodic pattern.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_pattern_t'($urandom_range(0, 3));
      stall_span = $urandom_range(16, 160);
    end
    stall_span--;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (stall_span % 6) < 2;
      endcase
    end
  end

  // Every beat accepted by the receiver goes straight to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_beat(profile_value, profile_index, frame_last);
  end

  // Write one register; the caller lowers the write enable after its last write so that
  // back-to-back writes keep it high without a second assignment in the same step.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic apply_config(input bit tm, input bit whole, input int lo, input int hi,
                              input bit norm, input int unsigned nch, input int unsigned nt);
    cfg_write(REG_TEMPORAL_MODE, CFG_DATA_W'(tm));
    cfg_write(REG_TAKE_WHOLE,    CFG_DATA_W'(whole));
    cfg_write(REG_WINDOW_LOW,    lo[CFG_DATA_W-1:0]);
    cfg_write(REG_WINDOW_HIGH,   hi[CFG_DATA_W-1:0]);
    cfg_write(REG_NORMALIZE,     CFG_DATA_W'(norm));
    cfg_write(REG_CHANNELS,      CFG_DATA_W'(nch[NCH_W-1:0]));
    cfg_write(REG_SAMPLES,       CFG_DATA_W'(nt[NT_W-1:0]));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Offer one sample and wait until it is taken. The sender runs in bursts of random
  // length; a random gap, sometimes none, separates one burst from the next.
  task automatic feed(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
    burst_left--;
  endtask

  // Wait until every predicted beat has arrived and the block has had time to finish
  // any sample that produces no beat.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(sample_style_t style);
    logic signed [SAMPLE_W-1:0] v;
    v = SAMPLE_W'($urandom);
    if (style == STYLE_MIN) begin
      v = S_MIN;
    end else if (style == STYLE_EXTREME || $urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0:       v = S_MAX;
        1:       v = S_MIN;
        2:       v = '0;
        default: v = '1;
      endcase
    end else if (style == STYLE_SMALL) begin
      v = SAMPLE_W'($urandom_range(0, 16));
      v = v - 24'sd8;
    end
    return v;
  endfunction

  // Window limits mostly fall around the active axis so that clamping, empty and
  // inverted windows all happen; the rest are the 16-bit extremes or fully random.
  function automatic int draw_limit(int axis);
    logic signed [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       return -32768;
      1:       return 32767;
      2:       return int'(r);
      default: return int'($urandom_range(0, axis + 4)) - 2;
    endcase
  endfunction

  // One phase: settle, write a full setting, finish any open frame, then send whole frames
  // and, in spectral mode only, possibly a broken tail that leaves a frame open.
  task automatic run_phase(input bit tm, input bit whole, input int lo, input int hi,
                           input bit norm, input int unsigned nch, input int unsigned nt,
                           input int frames, input bit partial, input sample_style_t style);
    int count;
    int fs;
    settle();
    apply_config(tm, whole, lo, hi, norm, nch, nt);
    fs    = sb.frame_size();
    count = sb.samples_to_frame_end() + frames * fs;
    if (partial && fs > 1) count += $urandom_range(1, fs - 1);
    repeat (count) feed(draw_sample(style));
  endtask

  task automatic run_directed();
    // Spectral mode, two channels of three samples, limits far outside the axis, mean.
    apply_config(1'b0, 1'b0, -32768, 32767, 1'b1, 2, 3);
    feed(S_MAX); feed(S_MAX); feed(S_MIN);
    feed(S_MIN); feed('0);    feed('1);
    settle();
    // Temporal mode, two channels by two times, window holding channel 1 only. Two frames,
    // so the second frame's first channel has to overwrite the stored sums.
    apply_config(1'b1, 1'b0, 1, 2, 1'b1, 2, 2);
    feed(S_MIN); feed(S_MAX); feed(S_MAX); feed(S_MIN);
    feed(24'sd1); feed(S_MAX); feed('1);   feed(S_MIN);
    settle();
    // An inverted window sums nothing and divides by one.
    apply_config(1'b0, 1'b0, 3, 1, 1'b1, 1, 2);
    feed(S_MAX); feed(S_MAX);
    settle();
    // Zero frame sizes act as a frame of one channel with one sample.
    apply_config(1'b1, 1'b1, 0, 0, 1'b1, 0, 0);
    feed(S_MIN); feed(S_MAX);
    settle();
    // Shrink the frame in the middle: the time counter sits past the new last index, so
    // the next sample closes the channel; then the channel count drops below the current
    // channel, so the next channel end closes the frame.
    apply_config(1'b0, 1'b1, 0, 0, 1'b0, 3, 6);
    feed(S_MAX); feed(24'sd5); feed(S_MIN); feed('1);
    settle();
    apply_config(1'b0, 1'b1, 0, 0, 1'b0, 3, 2);
    feed(24'sd7); feed(S_MAX);
    settle();
    apply_config(1'b0, 1'b1, 0, 0, 1'b0, 1, 2);
    feed(S_MIN);
    settle();
  endtask

  // Safety net against a hung handshake.
  initial begin
    while (cycles < LIMIT_CYCLES) @(posedge clk);
    $display("Timeout after %0d cycles with %0d beats outstanding", cycles, sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    bit          tm;
    int unsigned nch;
    int unsigned nt;
    int          axis;
    int          target;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // Size registers above the maximum act as the maximum: start such a frame with a few
    // samples and leave it open, so the first random phase shrinks and closes it.
    apply_config(1'b0, 1'b1, 0, 0, 1'b0, 511, 2047);
    repeat (5) feed(draw_sample(STYLE_FULL));

    // Random small frames. Temporal mode is only entered on a frame boundary, so every
    // per-time sum read was written earlier in the same frame.
    target = sb.noted + RANDOM_ITEMS;
    while (sb.noted < target) begin
      tm  = sb.at_frame_start() ? 1'($urandom_range(0, 1)) : 1'b0;
      nch = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      case ($urandom_range(0, 9))
        0:       nt = 0;
        1:       nt = $urandom_range(13, 40);
        default: nt = $urandom_range(1, 12);
      endcase
      axis = tm ? sb.fit_size(nch, MAX_CHANNELS) : sb.fit_size(nt, MAX_TIME);
      run_phase(tm, ($urandom_range(0, 3) == 0), draw_limit(axis), draw_limit(axis),
                1'($urandom_range(0, 1)), nch, nt, $urandom_range(1, 3),
                !tm && ($urandom_range(0, 3) == 0),
                ($urandom_range(0, 4) == 0) ? STYLE_SMALL :
                ($urandom_range(0, 3) == 0) ? STYLE_EXTREME : STYLE_FULL);
    end

    settle();
    $display("Summary: %0d samples in, %0d profile beats checked, %0d register settings.",
             sb.noted, sb.checked, settings_used);
    $display("Summary: spectral and temporal frames, clamped windows, mid-frame shrink.");
    if (sb.pending() != 0)
      $display("%0d predicted beats never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/isp_pkg.sv
sv/isp_div.sv
sv/image_slice_profile.sv
sv/isp_check.sv
tb/sv/tb_image_slice_profile.sv
